// File: design/per_document_top_k_label_keeper_assert.svh
// Assertion macros for the per-document top-K label keeper.
// Expects signals clk and arst_n in the module that uses them.
`ifndef PER_DOCUMENT_TOP_K_LABEL_KEEPER_ASSERT_SVH
`define PER_DOCUMENT_TOP_K_LABEL_KEEPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTK_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTK_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ptk_pkg.sv
// Package for the per-document top-K label keeper: sizes, codes and types.
// Used by ptk_insert and per_document_top_k_label_keeper; depends on nothing.
package ptk_pkg;

	localparam int K_MAX       = 16;
	localparam int DOC_COUNT   = 1024;
	localparam int LABEL_WIDTH = 20;

	localparam int DOC_W   = 10;
	localparam int IDX_W   = $clog2(K_MAX);
	localparam int CNT_W   = $clog2(K_MAX + 1);
	localparam int SCORE_W = 32;
	localparam int ADDR_W  = $clog2(DOC_COUNT);

	// Operation codes carried in the input tuser.
	typedef enum logic [1:0] {
		FN_SET_LIMIT = 2'd0,
		FN_OFFER     = 2'd1,
		FN_READ      = 2'd2,
		FN_NONE      = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [LABEL_WIDTH-1:0]    label;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef entry_t [K_MAX-1:0] row_t;

	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] limit;
	} meta_t;

	// Insertion request: slot that takes the new entry before it moves up.
	typedef struct packed {
		logic [IDX_W-1:0] slot;
		entry_t           ent;
	} ins_req_t;

	// Round a Q16.16 count half away from zero and clamp it to 1..K_MAX.
	function automatic logic [CNT_W-1:0] limit_from_count(logic signed [SCORE_W-1:0] q);
		logic [SCORE_W:0]    sum;
		logic [SCORE_W-16:0] n;
		logic [CNT_W-1:0]    res;
		sum = {1'b0, q} + (SCORE_W+1)'(32'h8000);
		n   = sum[SCORE_W:16];
		if (q < 0 || n == '0) begin
			res = CNT_W'(1);
		end else if (n > (SCORE_W-15)'(K_MAX)) begin
			res = CNT_W'(K_MAX);
		end else begin
			res = CNT_W'(n);
		end
		return res;
	endfunction

endpackage

// File: design/per_document_top_k_label_keeper.sv
// Top level of the per-document top-K label keeper: row and count memories,
// sequencer and output register. Depends on ptk_pkg, ptk_insert and the assert header.
//
// Usage: items arrive on the s_ channel; tuser carries the operation (set limit,
// offer, read) and tdata the document, label and Q16.16 value. In an offer, the
// document's row and its fill/limit word are read from synchronous memories,
// then the row is re-sorted with a parallel compare-shift and written back. A
// read reads the same memories first, then gives one result per cycle on the m_
// channel while the receiver does not stall, with tlast on the final one; an
// empty list gives one result with valid_res clear. Items are handled one at a
// time: s_tready is high only while the sequencer is idle. After reset a
// clearing pass over all DOC_COUNT (1024) documents writes every document's
// fill count to zero and its limit to one; no item is accepted meanwhile.
// When the receiver stalls, the result waits in the output register and the
// stream of results pauses; a new item is accepted once the last result of a
// read sits in that register.
`include "per_document_top_k_label_keeper_assert.svh"

module per_document_top_k_label_keeper
	import ptk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // doc_index[9:0], label_id[29:10], value[61:30], zero
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // valid_res[0], rank[4:1], out_label[24:5], out_score[56:25], zero
	output logic        m_tlast
);

	// Memories.
	row_t  row_mem [DOC_COUNT];
	meta_t meta_mem [DOC_COUNT];
	row_t  row_rd_q;
	meta_t meta_rd_q;

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	func_t             func_s1;
	logic [ADDR_W-1:0] addr_s1;
	entry_t            ent_s1;
	logic              inr_s1;
	logic [IDX_W-1:0]  r_q;
	logic [CNT_W-1:0]  tot_q;
	logic              empty_q;

	logic              m_tvalid_q, m_tlast_q;
	logic [63:0]       m_tdata_q;

	// Input unpacking.
	func_t             in_func;
	logic [DOC_W-1:0]  in_doc;
	entry_t            in_ent;
	logic              in_range;
	logic              acc;

	assign in_func      = func_t'(s_tuser);
	assign in_doc       = s_tdata[9:0];
	assign in_ent.label = s_tdata[29:10];
	assign in_ent.score = s_tdata[61:30];
	assign in_range     = 32'(in_doc) < DOC_COUNT;
	assign acc          = s_tvalid && s_tready;

	// Combinational control.
	logic              meta_we, row_we, rd_en, ld_out;
	logic [ADDR_W-1:0] meta_wa;
	meta_t             meta_wd;
	ins_req_t          ins_req;
	row_t              row_new;
	logic [CNT_W-1:0]  n_eff;

	ptk_insert u_insert (
		.row_in  (row_rd_q),
		.req     (ins_req),
		.row_out (row_new)
	);

	assign n_eff = (meta_rd_q.fill > CNT_W'(K_MAX)) ? CNT_W'(K_MAX) : meta_rd_q.fill;

	// Next state, memory writes and output loading.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		meta_we      = 1'b0;
		meta_wa      = addr_s1;
		meta_wd      = meta_rd_q;
		row_we       = 1'b0;
		rd_en        = 1'b0;
		ld_out       = 1'b0;
		ins_req.ent  = ent_s1;
		ins_req.slot = IDX_W'(meta_rd_q.fill);
		case (state_q)
			ST_CLEAR: begin
				meta_we       = 1'b1;
				meta_wa       = clr_q;
				meta_wd.fill  = '0;
				meta_wd.limit = CNT_W'(1);
				if (32'(clr_q) == DOC_COUNT - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && in_range && in_func == FN_SET_LIMIT) begin
					meta_we       = 1'b1;
					meta_wa       = ADDR_W'(in_doc);
					meta_wd.fill  = '0;
					meta_wd.limit = limit_from_count(in_ent.score);
				end
				if (acc && (in_func == FN_OFFER || in_func == FN_READ)) begin
					rd_en   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (func_s1 == FN_OFFER) begin
					state_d = ST_IDLE;
					if (inr_s1 && meta_rd_q.fill < meta_rd_q.limit) begin
						row_we       = 1'b1;
						meta_we      = 1'b1;
						meta_wd.fill = meta_rd_q.fill + CNT_W'(1);
					end else if (inr_s1 && meta_rd_q.fill != '0 &&
						ent_s1.score > row_rd_q[IDX_W'(meta_rd_q.fill - CNT_W'(1))].score) begin
						row_we       = 1'b1;
						ins_req.slot = IDX_W'(meta_rd_q.fill - CNT_W'(1));
					end
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ld_out = !m_tvalid_q || m_tready;
				if (ld_out && CNT_W'(r_q) + CNT_W'(1) >= tot_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory ports: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		if (row_we) begin
			row_mem[addr_s1] <= row_new;
		end
		if (rd_en) begin
			meta_rd_q <= meta_mem[ADDR_W'(in_doc)];
			row_rd_q  <= row_mem[ADDR_W'(in_doc)];
		end
	end

	// Sequencer state and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (acc) begin
			func_s1 <= in_func;
			addr_s1 <= ADDR_W'(in_doc);
			ent_s1  <= in_ent;
			inr_s1  <= in_range;
		end
	end

	// Read bookkeeping: result count and rank counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			tot_q   <= CNT_W'(1);
			empty_q <= 1'b1;
		end else if (state_q == ST_EXEC) begin
			r_q     <= '0;
			empty_q <= !inr_s1 || n_eff == '0;
			tot_q   <= (!inr_s1 || n_eff == '0) ? CNT_W'(1) : n_eff;
		end else if (ld_out) begin
			r_q <= r_q + IDX_W'(1);
		end
	end

	// Output register: holds a transfer until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ld_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			m_tlast_q <= CNT_W'(r_q) + CNT_W'(1) >= tot_q;
			if (empty_q) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {7'd0, row_rd_q[r_q].score, 20'(row_rd_q[r_q].label),
					r_q, 1'b1};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks on the sequencer.
	`PTK_ASSERT_IMP(a_no_accept_clear, state_q == ST_CLEAR, !s_tready,
		"item accepted during clearing pass")
	`PTK_ASSERT_IMP(a_row_write_exec, row_we, state_q == ST_EXEC && func_s1 == FN_OFFER,
		"row written outside an offer")
	`PTK_ASSERT_IMP(a_fill_le_limit, state_q == ST_EXEC && inr_s1,
		meta_rd_q.fill <= meta_rd_q.limit, "fill count above limit")
	`PTK_ASSERT_IMP(a_rank_in_range, state_q == ST_EMIT, CNT_W'(r_q) < tot_q,
		"rank counter beyond list length")
	`PTK_ASSERT_NXT(a_exec_one_cycle, state_q == ST_EXEC, state_q != ST_EXEC,
		"update stage held more than one cycle")

endmodule

// File: design/ptk_insert.sv
// Parallel compare-shift that places one entry into a sorted row.
// Depends on ptk_pkg.
module ptk_insert
	import ptk_pkg::*;
(
	input  row_t     row_in,
	input  ins_req_t req,
	output row_t     row_out
);

	logic [K_MAX-1:0] keep;

	// An older entry stays ahead when its score is not below the new one.
	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			keep[i] = (IDX_W'(i) < req.slot) && (row_in[i].score >= req.ent.score);
		end
	end

	// Entries between the insertion point and the slot move down by one.
	always_comb begin
		for (int i = 0; i < K_MAX; i++) begin
			if (IDX_W'(i) > req.slot || keep[i]) begin
				row_out[i] = row_in[i];
			end else if (i == 0) begin
				row_out[i] = req.ent;
			end else if (keep[i-1]) begin
				row_out[i] = req.ent;
			end else begin
				row_out[i] = row_in[i-1];
			end
		end
	end

endmodule

// File: verif/tb_per_document_top_k_label_keeper.sv
// Testbench for the per-document top-K label keeper: drives set-limit, offer and read
// transfers and checks every result transfer against a predicted list. Depends on ptk_pkg.
module tb_per_document_top_k_label_keeper
	import ptk_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	// One expected result transfer.
	typedef struct {
		logic        valid_res;
		logic [3:0]  rank;
		logic [19:0] out_label;
		logic [31:0] out_score;
		logic        last;
	} list_result_t;

	int fail_count = 0;

	// Scoreboard: keeps a model of every document list and the expected results.
	class label_list_board;
		logic [19:0]        lab [DOC_COUNT][K_MAX];
		logic signed [31:0] scr [DOC_COUNT][K_MAX];
		int                 fill [DOC_COUNT];
		int                 lim [DOC_COUNT];
		list_result_t       pending [$];

		function new();
			for (int d = 0; d < DOC_COUNT; d++) begin
				fill[d] = 0;
				lim[d] = 1;
			end
		endfunction

		function int round_count(logic signed [31:0] q);
			longint n;
			if (q < 0) return 1;
			n = (longint'(q) + 32768) >>> 16;
			if (n < 1) n = 1;
			if (n > K_MAX) n = K_MAX;
			return int'(n);
		endfunction

		// Note an accepted input transfer.
		function void note_item(func_t fn, int doc, logic [19:0] label, logic signed [31:0] v);
			int n, p;
			logic [19:0] hl;
			logic signed [31:0] hs;
			list_result_t r;
			case (fn)
				FN_SET_LIMIT: begin
					lim[doc] = round_count(v);
					fill[doc] = 0;
				end
				FN_OFFER: begin
					n = fill[doc];
					if (n < lim[doc]) begin
						lab[doc][n] = label;
						scr[doc][n] = v;
						n++;
						fill[doc] = n;
					end else if (v > scr[doc][n-1]) begin
						lab[doc][n-1] = label;
						scr[doc][n-1] = v;
					end
					p = n - 1;
					hl = lab[doc][p];
					hs = scr[doc][p];
					while (p > 0 && hs > scr[doc][p-1]) begin
						lab[doc][p] = lab[doc][p-1];
						scr[doc][p] = scr[doc][p-1];
						p--;
					end
					lab[doc][p] = hl;
					scr[doc][p] = hs;
				end
				FN_READ: begin
					n = fill[doc];
					if (n == 0) begin
						r = '{1'b0, 4'd0, 20'd0, 32'd0, 1'b1};
						pending.insert(pending.size(), r);
					end
					for (int k = 0; k < n; k++) begin
						r = '{1'b1, 4'(k), lab[doc][k], scr[doc][k], k == n - 1};
						pending.insert(pending.size(), r);
					end
				end
				default: ;
			endcase
		endfunction

		// Check one accepted result transfer against the oldest expectation.
		function void check_result(logic [63:0] d, logic tl);
			list_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer %h", d);
				fail_count++;
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.valid_res) begin
				$error("valid_res expected %0d actual %0d", e.valid_res, d[0]);
				fail_count++;
			end
			if (d[4:1] !== e.rank) begin
				$error("rank expected %0d actual %0d", e.rank, d[4:1]);
				fail_count++;
			end
			if (d[24:5] !== e.out_label) begin
				$error("out_label expected %h actual %h", e.out_label, d[24:5]);
				fail_count++;
			end
			if (d[56:25] !== e.out_score) begin
				$error("out_score expected %h actual %h", e.out_score, d[56:25]);
				fail_count++;
			end
			if (tl !== e.last) begin
				$error("last expected %0d actual %0d", e.last, tl);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;

	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;
	label_list_board board;

	always #6 clk = ~clk;

	per_document_top_k_label_keeper DUT (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	// Result side: random stalls, checks at the rising edge.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	// Watchdog on cycles with no transfer at all.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Send one item; tvalid drops only during inserted gaps, so items can follow back to back.
	task automatic send_item(func_t fn, int doc, logic [19:0] label, logic [31:0] v);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {2'b00, v, label, doc[9:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_item(fn, doc, label, v);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_score();
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(7)) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int count);
		int doc;
		int r;
		for (int i = 0; i < count; i++) begin
			doc = (i % 9 == 0) ? $urandom_range(1023) : $urandom_range(7);
			r = $urandom_range(99);
			if (r < 10)
				send_item(FN_SET_LIMIT, doc, 20'($urandom),
					($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(18)) << 15);
			else if (r < 70) send_item(FN_OFFER, doc, 20'($urandom), rand_score());
			else if (r < 95) send_item(FN_READ, doc, 20'($urandom), $urandom);
			else send_item(FN_NONE, doc, 20'($urandom), $urandom);
		end
	endtask

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty read, limit rounding and clamps, ties, full list, unused code.
		send_idle = 27; recv_idle = 83;
		send_item(FN_READ, 0, 0, 0);
		send_item(FN_OFFER, 1, 20'hFFFFF, 32'h7FFF_FFFF);
		send_item(FN_OFFER, 1, 20'h00001, 32'h8000_0000);
		send_item(FN_READ, 1, 0, 0);
		send_item(FN_SET_LIMIT, 2, 0, 32'h0002_8000);
		send_item(FN_OFFER, 2, 20'h00010, 32'h0001_0000);
		send_item(FN_OFFER, 2, 20'h00020, 32'h0001_0000);
		send_item(FN_OFFER, 2, 20'h00030, 32'h0001_0000);
		send_item(FN_OFFER, 2, 20'h00040, 32'h0001_0000);
		send_item(FN_OFFER, 2, 20'h00050, 32'h0002_0000);
		send_item(FN_READ, 2, 0, 0);
		send_item(FN_SET_LIMIT, 3, 0, 32'h7FFF_FFFF);
		for (int k = 0; k < 17; k++) send_item(FN_OFFER, 3, 20'(k), 32'(k * 3 - 20));
		send_item(FN_READ, 3, 0, 0);
		send_item(FN_SET_LIMIT, 4, 0, 32'h8000_0000);
		send_item(FN_SET_LIMIT, 5, 0, 32'h0000_7FFF);
		send_item(FN_NONE, 3, 0, 0);
		send_item(FN_READ, 3, 0, 0);
		send_item(FN_READ, 1023, 0, 0);
		for (int d = 0; d < 8; d++) send_item(FN_SET_LIMIT, d, 0, 32'($urandom_range(17)) << 16);

		random_phase(65);
		// Hold off until every pending result has arrived.
		drain();
		send_idle = 83; recv_idle = 27;
		random_phase(61);
		send_idle = 0; recv_idle = 0;
		random_phase(61);
		drain();

		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// File: files.f
+incdir+design
design/ptk_pkg.sv
design/ptk_insert.sv
design/per_document_top_k_label_keeper.sv
verif/tb_per_document_top_k_label_keeper.sv
